@@ src/gtg_pkg.sv @@
// Shared types, register map, codes and the arctangent table of the steering controller.
package gtg_pkg;

  localparam int WINDOW_START = 300;
  localparam int WINDOW_END = 420;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_W = $clog2(ATAN_ENTRIES);

  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 32;
  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    FUNC_ODOM = 2'd0,
    FUNC_SCAN = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_ARRIVED = 2'd0,
    MODE_PIVOT = 2'd1,
    MODE_TURN = 2'd2,
    MODE_DRIVE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_GOAL_X = 3'd0,
    REG_GOAL_Y = 3'd1,
    REG_DRIVE_SPEED = 3'd2,
    REG_PIVOT_SPEED = 3'd3,
    REG_ARRIVE_DISTANCE = 3'd4,
    REG_HEADING_TOLERANCE = 3'd5,
    REG_OBSTACLE_DISTANCE = 3'd6,
    REG_UNUSED = 3'd7
  } reg_index_t;

  function automatic logic [15:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [15:0] v;
    case (i)
      5'd0: v = 16'd8192;
      5'd1: v = 16'd4836;
      5'd2: v = 16'd2555;
      5'd3: v = 16'd1297;
      5'd4: v = 16'd651;
      5'd5: v = 16'd326;
      5'd6: v = 16'd163;
      5'd7: v = 16'd81;
      5'd8: v = 16'd41;
      5'd9: v = 16'd20;
      5'd10: v = 16'd10;
      5'd11: v = 16'd5;
      5'd12: v = 16'd3;
      5'd13: v = 16'd1;
      5'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/go_to_goal_steering_controller_core.sv @@
// Top level of the go-to-goal steering controller with obstacle pivot.
//
// Input items arrive on the s_ stream; tuser carries the event kind and
// tlast marks the last range sample of a scan. Odometry and scan items are
// absorbed in the cycle they are accepted and give no result. A control tick
// gives one steering command on the m_ stream, with the mode in tuser.
// A tick passes through these steps before its command is offered: the goal
// vector is formed as the item is accepted, then three passes through the
// shared 17 by 17 bit multiplier for the squared distance and squared
// radius, CORDIC iterations at one per cycle, and a decision state that
// chooses the mode. s_tready is low throughout that work, so no further item is
// taken until the command has been registered. A finished command waits in the
// output register while the receiver stalls; further odometry and scan items
// are still taken, and a following tick runs up to its decision and then
// waits for the register to empty. Reset is synchronous: it loads the
// register defaults, clears the pose and the obstacle flag, sets the window
// minimum to all ones and empties the output register. Configuration is
// written through the APB port, one register per word at address 4*i.
module go_to_goal_steering_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pos_x, pos_y, heading, range_sample, sample_index, zero fill
  input  logic [gtg_pkg::IN_DATA_W-1:0] s_tdata,
  // func
  input  logic [1:0]                    s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // linear_cmd, angular_cmd, zero fill
  output logic [gtg_pkg::OUT_DATA_W-1:0] m_tdata,
  // mode
  output logic [1:0]                    m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gtg_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gtg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQX    = 6'b000010,
    ST_SQY    = 6'b000100,
    ST_SQT    = 6'b001000,
    ST_ROT    = 6'b010000,
    ST_DECIDE = 6'b100000
  } state_t;

  state_t state;

  logic [15:0] goal_x, goal_y, obstacle_distance;
  logic [11:0] drive_speed, pivot_speed;
  logic [14:0] arrive_distance, heading_tolerance;

  logic [15:0] here_x, here_y, here_heading, window_min;
  logic        blocked;

  logic signed [16:0] dx, dy;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic [33:0]        acc;
  logic signed [35:0] cx, cy, xs, ys, x0;
  logic [15:0]        cz;
  logic [STEP_W-1:0]  step;

  logic [15:0] in_pos_x, in_pos_y, in_heading, in_range;
  logic [9:0]  in_index;
  logic        accept, in_window, out_free;
  logic [15:0] scan_min;
  logic [2:0]  reg_sel;
  logic        cfg_write;

  logic [15:0]        angle, err;
  logic signed [16:0] err_mag;
  logic [12:0]        pivot_pos;
  logic [11:0]        lin_next;
  logic [12:0]        ang_next;
  mode_t              mode_next;

  assign in_pos_x   = s_tdata[15:0];
  assign in_pos_y   = s_tdata[31:16];
  assign in_heading = s_tdata[47:32];
  assign in_range   = s_tdata[63:48];
  assign in_index   = s_tdata[73:64];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign in_window = ({1'b0, in_index} >= 11'(WINDOW_START)) &&
                     ({1'b0, in_index} < 11'(WINDOW_END));
  assign scan_min  = (in_window && (in_range < window_min)) ? in_range : window_min;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = 32'd0;
    unique case (reg_index_t'(reg_sel))
      REG_GOAL_X:            prdata = {16'd0, goal_x};
      REG_GOAL_Y:            prdata = {16'd0, goal_y};
      REG_DRIVE_SPEED:       prdata = {20'd0, drive_speed};
      REG_PIVOT_SPEED:       prdata = {20'd0, pivot_speed};
      REG_ARRIVE_DISTANCE:   prdata = {17'd0, arrive_distance};
      REG_HEADING_TOLERANCE: prdata = {17'd0, heading_tolerance};
      REG_OBSTACLE_DISTANCE: prdata = {16'd0, obstacle_distance};
      default:               prdata = 32'd0;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = dx;
    mul_b = dx;
    unique case (state)
      ST_SQY: begin
        mul_a = dy;
        mul_b = dy;
      end
      ST_SQT: begin
        mul_a = $signed({2'b00, arrive_distance});
        mul_b = $signed({2'b00, arrive_distance});
      end
      default: begin
        mul_a = dx;
        mul_b = dx;
      end
    endcase
  end

  assign x0 = {{3{dx[16]}}, dx, 16'd0};
  assign xs = cx >>> step;
  assign ys = cy >>> step;

  // Mode decision from the squared distance, the obstacle flag and the heading error.
  always_comb begin
    angle     = ((dx == 17'sd0) && (dy == 17'sd0)) ? 16'd0 : cz;
    err       = angle - here_heading;
    err_mag   = err[15] ? -$signed({err[15], err}) : $signed({err[15], err});
    pivot_pos = {1'b0, pivot_speed};
    lin_next  = 12'd0;
    ang_next  = 13'd0;
    if (acc < $unsigned(prod)) begin
      mode_next = MODE_ARRIVED;
    end else if (blocked) begin
      mode_next = MODE_PIVOT;
      ang_next  = pivot_pos;
    end else if (err_mag > $signed({2'b00, heading_tolerance})) begin
      mode_next = MODE_TURN;
      ang_next  = err[15] ? -pivot_pos : pivot_pos;
    end else begin
      mode_next = MODE_DRIVE;
      lin_next  = drive_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      goal_x            <= 16'd4000;
      goal_y            <= 16'd3500;
      drive_speed       <= 12'd500;
      pivot_speed       <= 12'd600;
      arrive_distance   <= 15'd300;
      heading_tolerance <= 15'd1565;
      obstacle_distance <= 16'd800;
      here_x            <= 16'd0;
      here_y            <= 16'd0;
      here_heading      <= 16'd0;
      window_min        <= 16'hFFFF;
      blocked           <= 1'b0;
      m_tvalid          <= 1'b0;
      step              <= '0;
    end else begin
      if (cfg_write) begin
        unique case (reg_index_t'(reg_sel))
          REG_GOAL_X:            goal_x <= pwdata[15:0];
          REG_GOAL_Y:            goal_y <= pwdata[15:0];
          REG_DRIVE_SPEED:       drive_speed <= pwdata[11:0];
          REG_PIVOT_SPEED:       pivot_speed <= pwdata[11:0];
          REG_ARRIVE_DISTANCE:   arrive_distance <= pwdata[14:0];
          REG_HEADING_TOLERANCE: heading_tolerance <= pwdata[14:0];
          REG_OBSTACLE_DISTANCE: obstacle_distance <= pwdata[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != ST_DECIDE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (func_t'(s_tuser))
              FUNC_ODOM: begin
                here_x       <= in_pos_x;
                here_y       <= in_pos_y;
                here_heading <= in_heading;
              end
              FUNC_SCAN: begin
                if (s_tlast) begin
                  blocked    <= scan_min < obstacle_distance;
                  window_min <= 16'hFFFF;
                end else begin
                  window_min <= scan_min;
                end
              end
              FUNC_TICK: state <= ST_SQX;
              default: ;
            endcase
          end
        end
        ST_SQX: state <= ST_SQY;
        ST_SQY: state <= ST_SQT;
        ST_SQT: begin
          state <= ST_ROT;
          step  <= '0;
        end
        ST_ROT: begin
          step <= step + 1'b1;
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept && (func_t'(s_tuser) == FUNC_TICK)) begin
      dx <= $signed({goal_x[15], goal_x}) - $signed({here_x[15], here_x});
      dy <= $signed({goal_y[15], goal_y}) - $signed({here_y[15], here_y});
    end
    if ((state == ST_SQX) || (state == ST_SQY) || (state == ST_SQT)) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_SQY) begin
      acc <= $unsigned(prod);
    end
    if (state == ST_SQT) begin
      acc <= acc + $unsigned(prod);
      if (dx[16]) begin
        cx <= -x0;
        cy <= -{{3{dy[16]}}, dy, 16'd0};
        cz <= 16'd32768;
      end else begin
        cx <= x0;
        cy <= {{3{dy[16]}}, dy, 16'd0};
        cz <= 16'd0;
      end
    end
    if (state == ST_ROT) begin
      if (!cy[35]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_entry(step);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_entry(step);
      end
    end
    if ((state == ST_DECIDE) && out_free) begin
      m_tdata <= {7'd0, ang_next, lin_next};
      m_tuser <= mode_next;
    end
  end

endmodule

@@ src/gtg_checker.sv @@
// Port-level checker for the steering controller, bound to its top level.
module gtg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [1:0]                     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gtg_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser
);
  import gtg_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result item changed or was dropped.");

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FUNC_TICK) |=> !s_tready)
    else $error("Input accepted while a control tick is being worked on.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == MODE_ARRIVED) |-> m_tdata == '0)
    else $error("Arrived command carries a non-zero speed.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == MODE_DRIVE) |-> m_tdata[24:12] == 13'd0)
    else $error("Drive command carries a turn rate.");

endmodule

bind go_to_goal_steering_controller_core gtg_checker u_gtg_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser(s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);

@@ tb/go_to_goal_steering_controller_core_tb.sv @@
// Self-checking testbench for the go-to-goal steering controller core.
module go_to_goal_steering_controller_core_tb;
  import gtg_pkg::*;

  typedef struct {
    func_t       func;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] heading;
    logic [15:0] range_mm;
    logic [9:0]  index;
    logic        scan_end;
  } sense_item_t;

  typedef struct {
    logic [11:0] linear;
    logic [12:0] angular;
    mode_t       mode;
  } steer_cmd_t;

  localparam int HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  logic [15:0] cfg_goal_x = 16'd4000;
  logic [15:0] cfg_goal_y = 16'd3500;
  logic [11:0] cfg_drive = 12'd500;
  logic [11:0] cfg_pivot = 12'd600;
  logic [14:0] cfg_arrive = 15'd300;
  logic [14:0] cfg_tolerance = 15'd1565;
  logic [15:0] cfg_obstacle = 16'd800;

  logic [15:0] here_x = '0;
  logic [15:0] here_y = '0;
  logic [15:0] here_heading = '0;
  logic [15:0] window_min = 16'hFFFF;
  logic        blocked = 1'b0;

  sense_item_t pending_events[$];
  steer_cmd_t  expected_cmds[$];
  sense_item_t cur;
  sense_item_t sensed;
  steer_cmd_t  want;

  int queued_items = 0;
  int accepted_items = 0;
  int item_total = 0;
  int settings_count = 0;
  int check_fail = 0;
  int readback_fail = 0;
  int mode_count[4] = '{0, 0, 0, 0};
  int idle_rate = 0;
  int src_gap = 0;
  int sink_stall = 0;
  int sink_hold = 0;
  int hold_asked = 0;
  int hold_served = 0;

  go_to_goal_steering_controller_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint atan_units(input int i);
    case (i)
      0: return 8192;
      1: return 4836;
      2: return 2555;
      3: return 1297;
      4: return 651;
      5: return 326;
      6: return 163;
      7: return 81;
      8: return 41;
      9: return 20;
      10: return 10;
      11: return 5;
      12: return 3;
      13: return 1;
      14: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] goal_bearing(input longint dx, input longint dy);
    longint x, y, z, xs, ys;
    if (dx == 0 && dy == 0) return 16'd0;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_units(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_units(i);
      end
    end
    return z[15:0];
  endfunction

  function automatic void predict_steering(input sense_item_t it);
    longint dx, dy, d2, t2, err, mag;
    logic [15:0] diff;
    steer_cmd_t cmd;
    case (it.func)
      FUNC_ODOM: begin
        here_x = it.pos_x;
        here_y = it.pos_y;
        here_heading = it.heading;
      end
      FUNC_SCAN: begin
        if (it.index >= WINDOW_START && it.index < WINDOW_END && it.range_mm < window_min)
          window_min = it.range_mm;
        if (it.scan_end) begin
          blocked = window_min < cfg_obstacle;
          window_min = 16'hFFFF;
        end
      end
      FUNC_TICK: begin
        dx = longint'(signed'(cfg_goal_x)) - longint'(signed'(here_x));
        dy = longint'(signed'(cfg_goal_y)) - longint'(signed'(here_y));
        d2 = dx * dx + dy * dy;
        t2 = longint'(cfg_arrive) * longint'(cfg_arrive);
        diff = goal_bearing(dx, dy) - here_heading;
        err = longint'(signed'(diff));
        mag = (err < 0) ? -err : err;
        cmd.linear = '0;
        cmd.angular = '0;
        if (d2 < t2) begin
          cmd.mode = MODE_ARRIVED;
        end else if (blocked) begin
          cmd.mode = MODE_PIVOT;
          cmd.angular = {1'b0, cfg_pivot};
        end else if (mag > longint'(cfg_tolerance)) begin
          cmd.mode = MODE_TURN;
          cmd.angular = (err > 0) ? {1'b0, cfg_pivot} : 13'(-int'(cfg_pivot));
        end else begin
          cmd.mode = MODE_DRIVE;
          cmd.linear = cfg_drive;
        end
        expected_cmds.push_back(cmd);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
        src_gap = $urandom_range(1, 18) - 1;
        s_tvalid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        cur = pending_events.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, cur.index, cur.range_mm, cur.heading, cur.pos_y, cur.pos_x};
        s_tuser <= cur.func;
        s_tlast <= cur.scan_end;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      sink_hold = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else if (idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
      sink_stall = $urandom_range(1, 18) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sensed.func = func_t'(s_tuser);
      sensed.pos_x = s_tdata[15:0];
      sensed.pos_y = s_tdata[31:16];
      sensed.heading = s_tdata[47:32];
      sensed.range_mm = s_tdata[63:48];
      sensed.index = s_tdata[73:64];
      sensed.scan_end = s_tlast;
      predict_steering(sensed);
      accepted_items++;
    end
    if (!rst && m_tvalid && m_tready) begin
      mode_count[m_tuser]++;
      if (expected_cmds.size() == 0) begin
        $display("%0t: command with none expected: expected none, actual lin %0d ang %0d mode %0d",
                 $time, m_tdata[11:0], m_tdata[24:12], m_tuser);
        check_fail++;
      end else begin
        want = expected_cmds.pop_front();
        if (m_tdata[11:0] !== want.linear) begin
          $display("%0t: linear_cmd expected %0d, actual %0d", $time, want.linear, m_tdata[11:0]);
          check_fail++;
        end
        if (m_tdata[24:12] !== want.angular) begin
          $display("%0t: angular_cmd expected %0d, actual %0d", $time,
                   signed'(want.angular), signed'(m_tdata[24:12]));
          check_fail++;
        end
        if (m_tuser !== want.mode) begin
          $display("%0t: mode expected %0d, actual %0d", $time, want.mode, m_tuser);
          check_fail++;
        end
      end
    end
  end

  task automatic write_reg(input reg_index_t r, input logic [31:0] value);
    logic [31:0] mask;
    case (r)
      REG_GOAL_X: begin mask = 32'hFFFF; cfg_goal_x = value[15:0]; end
      REG_GOAL_Y: begin mask = 32'hFFFF; cfg_goal_y = value[15:0]; end
      REG_DRIVE_SPEED: begin mask = 32'hFFF; cfg_drive = value[11:0]; end
      REG_PIVOT_SPEED: begin mask = 32'hFFF; cfg_pivot = value[11:0]; end
      REG_ARRIVE_DISTANCE: begin mask = 32'h7FFF; cfg_arrive = value[14:0]; end
      REG_HEADING_TOLERANCE: begin mask = 32'h7FFF; cfg_tolerance = value[14:0]; end
      REG_OBSTACLE_DISTANCE: begin mask = 32'hFFFF; cfg_obstacle = value[15:0]; end
      default: mask = '0;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= (value & mask) | ($urandom & ~mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register %0d read back expected %h, actual %h", $time, r, value & mask,
               prdata & mask);
      readback_fail++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] gx, input logic [15:0] gy,
                                input logic [11:0] drive, input logic [11:0] pivot,
                                input logic [14:0] arrive, input logic [14:0] tol,
                                input logic [15:0] obst);
    write_reg(REG_GOAL_X, 32'(gx));
    write_reg(REG_GOAL_Y, 32'(gy));
    write_reg(REG_DRIVE_SPEED, 32'(drive));
    write_reg(REG_PIVOT_SPEED, 32'(pivot));
    write_reg(REG_ARRIVE_DISTANCE, 32'(arrive));
    write_reg(REG_HEADING_TOLERANCE, 32'(tol));
    write_reg(REG_OBSTACLE_DISTANCE, 32'(obst));
    write_reg(REG_UNUSED, $urandom);
    settings_count++;
  endtask

  task automatic queue_event(input func_t f, input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] hd, input logic [15:0] rng,
                             input logic [9:0] idx, input logic scan_end);
    sense_item_t it;
    it.func = f;
    it.pos_x = px;
    it.pos_y = py;
    it.heading = hd;
    it.range_mm = rng;
    it.index = idx;
    it.scan_end = scan_end;
    pending_events.push_back(it);
    queued_items++;
    if (f != FUNC_NONE) item_total++;
  endtask

  task automatic queue_odom(input logic [15:0] px, input logic [15:0] py, input logic [15:0] hd);
    queue_event(FUNC_ODOM, px, py, hd, 16'($urandom), 10'($urandom), 1'($urandom));
  endtask

  task automatic queue_scan(input logic [9:0] idx, input logic [15:0] rng, input logic scan_end);
    queue_event(FUNC_SCAN, 16'($urandom), 16'($urandom), 16'($urandom), rng, idx, scan_end);
  endtask

  task automatic queue_tick();
    queue_event(FUNC_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                10'($urandom), 1'($urandom));
  endtask

  task automatic queue_random_burst(output int n);
    int pick, len, a, w;
    logic [15:0] px, py, hd, rng;
    logic [9:0] idx;
    longint dx, dy;
    n = 0;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        idx = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(280, 440))
                                         : 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 5))
          0, 1: rng = 16'(int'(cfg_obstacle) + int'($urandom_range(0, 100)) - 50);
          2: rng = 16'($urandom);
          3: rng = 16'hFFFF;
          default: rng = 16'($urandom_range(0, 2000));
        endcase
        queue_scan(idx, rng, k == len - 1 && $urandom_range(0, 9) != 0);
        n++;
      end
    end else if (pick < 70) begin
      a = int'(cfg_arrive);
      if ($urandom_range(0, 9) < 4) begin
        px = 16'(int'(signed'(cfg_goal_x)) + int'($urandom_range(0, 2 * a + 400)) - a - 200);
        py = 16'(int'(signed'(cfg_goal_y)) + int'($urandom_range(0, 2 * a + 400)) - a - 200);
      end else begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      if ($urandom_range(0, 1) == 1) begin
        dx = longint'(signed'(cfg_goal_x)) - longint'(signed'(px));
        dy = longint'(signed'(cfg_goal_y)) - longint'(signed'(py));
        w = int'(cfg_tolerance) + 300;
        hd = 16'(int'(goal_bearing(dx, dy)) + int'($urandom_range(0, 2 * w)) - w);
      end else begin
        hd = 16'($urandom);
      end
      queue_odom(px, py, hd);
      n++;
      if ($urandom_range(0, 2) != 0) begin
        queue_tick();
        n++;
      end
    end else if (pick < 95) begin
      queue_tick();
      n++;
    end else begin
      queue_event(FUNC_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  10'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain();
    while (accepted_items != queued_items || expected_cmds.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  initial begin
    int budget, n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    idle_rate = 15;

    // Default registers: pose extremes, the arrival boundary and the scan window edges.
    queue_tick();
    queue_odom(16'h7FFF, 16'h8000, 16'h7FFF);
    queue_tick();
    queue_odom(16'h8000, 16'h7FFF, 16'h8000);
    queue_tick();
    queue_odom(16'd4000, 16'd3500, 16'd0);
    queue_tick();
    queue_odom(16'd3700, 16'd3500, 16'd0);
    queue_tick();
    queue_odom(16'd3701, 16'd3500, 16'd0);
    queue_tick();
    queue_scan(10'd299, 16'd0, 1'b0);
    queue_scan(10'd420, 16'd0, 1'b0);
    queue_scan(10'd1023, 16'd0, 1'b0);
    queue_scan(10'd0, 16'd0, 1'b1);
    queue_odom(16'd0, 16'd0, goal_bearing(4000, 3500));
    queue_tick();
    queue_scan(10'd300, 16'hFFFF, 1'b0);
    queue_scan(10'd419, 16'd799, 1'b0);
    queue_scan(10'd350, 16'hFFFF, 1'b1);
    queue_tick();
    queue_scan(10'd419, 16'd800, 1'b1);
    queue_tick();
    queue_scan(10'd300, 16'd0, 1'b1);
    queue_event(FUNC_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 1'b1);
    queue_tick();
    queue_scan(10'd420, 16'd0, 1'b1);
    queue_tick();
    drain();

    // Goal at the origin with zero tolerance: zero goal vector and the half-turn error.
    apply_settings(16'd0, 16'd0, 12'd500, 12'd600, 15'd0, 15'd0, 16'd800);
    queue_odom(16'd0, 16'd0, 16'h8000);
    queue_tick();
    queue_odom(16'd0, 16'd0, 16'd0);
    queue_tick();
    queue_odom(16'd0, 16'd0, 16'd1);
    queue_tick();
    queue_odom(16'd0, 16'd0, 16'hFFFF);
    queue_tick();
    queue_odom(16'd1, 16'd0, 16'h8000);
    queue_tick();
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: apply_settings(16'h7FFF, 16'h7FFF, 12'hFFF, 12'hFFF, 15'h7FFF, 15'h7FFF, 16'hFFFF);
        3: apply_settings(16'h8000, 16'h8000, 12'd0, 12'd0, 15'd0, 15'd0, 16'd0);
        default: apply_settings(16'($urandom), 16'($urandom), 12'($urandom), 12'($urandom),
                                ($urandom_range(0, 1) == 1) ? 15'($urandom_range(0, 2000))
                                                            : 15'($urandom),
                                ($urandom_range(0, 1) == 1) ? 15'($urandom_range(0, 4000))
                                                            : 15'($urandom),
                                ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 3000))
                                                            : 16'($urandom));
      endcase
      idle_rate = (phase == 5) ? 0 : (phase == 4) ? 5 : 20;
      if (phase == 2) hold_asked++;
      budget = 0;
      while (budget < 230) begin
        queue_random_burst(n);
        budget += n;
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (expected_cmds.size() != 0) begin
      $display("%0t: commands outstanding expected 0, actual %0d", $time, expected_cmds.size());
      check_fail++;
    end
    $display("Ran %0d items under %0d register settings, with long output holds and drains.",
             item_total, settings_count);
    $display("Commands: %0d arrived, %0d pivot, %0d turn, %0d drive.",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    if (check_fail == 0 && readback_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
src/gtg_pkg.sv
src/go_to_goal_steering_controller_core.sv
src/gtg_checker.sv
tb/go_to_goal_steering_controller_core_tb.sv
